// ===== sv/hex_ascii_packet_deframer_macros.svh =====
// Assertion macros shared by the hex ASCII packet deframer RTL.
// Depends on nothing; files that assert include it by name.
`ifndef HEX_ASCII_PACKET_DEFRAMER_MACROS_SVH
`define HEX_ASCII_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HAPD_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HAPD_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== sv/hapd_pkg.sv =====
// Package for the hex ASCII packet deframer: payload types, decoder state,
// error codes and hex character helpers. Depends on nothing.
`default_nettype none

package hapd_pkg;

   // Default sizes of the packet header and the longest allowed packet.
   localparam int HEADER_BYTES_DEF     = 8;
   localparam int MAX_PACKET_BYTES_DEF = 64;

   // Error codes reported with a result.
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_HEADER   = 2'd1,
      ERR_TOO_LONG = 2'd2,
      ERR_BODY     = 2'd3
   } err_type;

   // One character of the received line.
   typedef struct packed {
      logic [7:0] char_code;
      logic       line_end;
   } req_type;

   // One decoded result.
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       packet_first;
      logic       packet_last;
      err_type    error_code;
   } rsp_type;

   // Decoder state carried from one character to the next.
   typedef struct packed {
      logic       nibble_pending;
      logic [3:0] high_nibble;
      logic [7:0] byte_index;
      logic [7:0] packet_length;
      logic       may_skip_separator;
      logic       dropping_line;
   } state_type;

   // True for the characters 0-9 and A-F.
   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   // Digit value of a hex character; anything else decodes as zero.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         v = c - 8'h30;
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/hapd_core.sv =====
// Character decoder of the hex ASCII packet deframer: holds the line state and
// turns each accepted character into zero or one result. Depends on hapd_pkg.
`default_nettype none

module hapd_core
   import hapd_pkg::*;
#(
   parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      step_en,
   input  wire req_type   req_item,
   output logic           res_valid,
   output rsp_type        res_item,
   output state_type      state
);

   localparam logic [8:0] HDR_LEN   = 9'(HEADER_BYTES);
   localparam logic [7:0] MAX_LEN   = 8'(MAX_PACKET_BYTES);
   localparam logic       HDR_MULTI = (HEADER_BYTES > 1);

   state_type  state_ff;
   state_type  state_in;
   logic       char_hex;
   logic [3:0] char_val;
   logic [7:0] data;
   logic [8:0] idx_ext;
   logic [8:0] idx_inc;
   logic [8:0] len_eff;
   logic [8:0] total;
   logic       last;

   assign state = state_ff;

   // Character classification and byte assembly.
   assign char_hex = is_hex(req_item.char_code);
   assign char_val = hex_value(req_item.char_code);
   assign data     = {state_ff.high_nibble, char_val};
   assign idx_ext  = {1'b0, state_ff.byte_index};
   assign idx_inc  = idx_ext + 9'd1;
   assign len_eff  = (state_ff.byte_index == 8'd0) ? {1'b0, data}
                                                   : {1'b0, state_ff.packet_length};
   assign total    = (len_eff < HDR_LEN) ? HDR_LEN : len_eff;
   assign last     = (idx_inc >= total);

   // Next state and result for the character on the request port.
   always_comb begin
      state_in  = state_ff;
      res_valid = 1'b0;
      res_item  = '0;
      if (state_ff.dropping_line) begin
         if (req_item.line_end) begin
            state_in = '0;
         end
      end else if (state_ff.may_skip_separator && !char_hex) begin
         state_in.may_skip_separator = 1'b0;
         if (req_item.line_end) begin
            state_in = '0;
         end
      end else if (!state_ff.nibble_pending) begin
         state_in.may_skip_separator = 1'b0;
         state_in.high_nibble        = char_val;
         state_in.nibble_pending     = 1'b1;
         if (req_item.line_end) begin
            state_in            = '0;
            res_valid           = 1'b1;
            res_item.error_code = (idx_ext < HDR_LEN) ? ERR_HEADER : ERR_BODY;
         end
      end else if ((state_ff.byte_index == 8'd0) && (data > MAX_LEN)) begin
         // Length byte over the limit ends this line's decoding.
         state_in               = '0;
         state_in.dropping_line = !req_item.line_end;
         res_valid              = 1'b1;
         res_item.error_code    = (req_item.line_end && HDR_MULTI) ? ERR_HEADER
                                                                   : ERR_TOO_LONG;
      end else begin
         state_in.may_skip_separator = 1'b0;
         state_in.nibble_pending     = 1'b0;
         state_in.high_nibble        = 4'd0;
         if (state_ff.byte_index == 8'd0) begin
            state_in.packet_length = data;
         end
         res_valid             = 1'b1;
         res_item.byte_valid   = 1'b1;
         res_item.data_byte    = data;
         res_item.packet_first = (state_ff.byte_index == 8'd0);
         res_item.packet_last  = last;
         if (req_item.line_end) begin
            state_in = '0;
            if (!last) begin
               res_item.error_code = (idx_inc < HDR_LEN) ? ERR_HEADER : ERR_BODY;
            end
         end else if (last) begin
            state_in.byte_index         = 8'd0;
            state_in.may_skip_separator = 1'b1;
         end else begin
            state_in.byte_index = idx_inc[7:0];
         end
      end
   end

   // Line state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/hex_ascii_packet_deframer.sv =====
// Hex ASCII packet deframer top level: character decoder plus a two-entry
// result buffer. Depends on hapd_pkg, hapd_core and the assertion macros.
//
//  Port group  Direction  Carries
//  req_*       in         one line character and its line-end flag
//  rsp_*       out        one decoded byte or an error report
//
// One character is taken every cycle while req_ready is high; a result, when there is
// one, is registered in the output register, or in the skid register if the output stalls.
// The decode is a single pass from the line state register to the result
// register; a skid register lets one more request in while a result stalls.
// Synchronous reset clears the line state and the valid flags of both result registers.
// req_ready drops only while both result registers are full.
`default_nettype none
`include "hex_ascii_packet_deframer_macros.svh"

module hex_ascii_packet_deframer
   import hapd_pkg::*;
#(
   parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_item
);

   logic      req_fire;
   logic      res_valid;
   rsp_type   res_item;
   state_type core_state;
   logic      push;
   logic      pop;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_item_ff;
   rsp_type   rsp_item_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   rsp_type   skid_item_ff;
   rsp_type   skid_item_in;

   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Character decoder and line state.
   hapd_core #(
      .HEADER_BYTES     (HEADER_BYTES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_fire),
      .req_item  (req_item),
      .res_valid (res_valid),
      .res_item  (res_item),
      .state     (core_state)
   );

   assign push = req_fire && res_valid;
   assign pop  = rsp_valid_ff && rsp_ready;

   // Output register with a skid register behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || pop) begin
         rsp_valid_in = push;
         rsp_item_in  = res_item;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_item_ff  <= rsp_item_in;
      skid_item_ff <= skid_item_in;
   end

   // A full skid register always sits behind a full output register.
   `HAPD_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid full while output empty")
   // Every accepted line end leaves the decoder in its clean state.
   `HAPD_ASSERT_NEXT(a_line_end_clears, clock, reset, req_fire && req_item.line_end, core_state == '0, "state not cleared after line end")
   // A result without a byte always reports an error.
   `HAPD_ASSERT_IMP(a_empty_result_err, clock, reset, rsp_valid && !rsp_item.byte_valid, rsp_item.error_code != ERR_NONE, "result with neither byte nor error")
   // While dropping a line no partial byte or packet position is held.
   `HAPD_ASSERT_IMP(a_drop_is_clean, clock, reset, core_state.dropping_line, !core_state.nibble_pending && core_state.byte_index == 8'd0, "dropping with live packet state")

endmodule

`default_nettype wire
